>>> hw/rtl/page_framebuffer_dirty_flush_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame buffer flush block
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DIRTY_FLUSH_MACROS_SVH
`define PAGE_FRAMEBUFFER_DIRTY_FLUSH_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define PFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfd: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfd: next-cycle check failed");
`else
`define PFD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Sizes, codes, beat types and helper functions of the frame buffer flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfd_pkg;

  localparam int COLUMNS = 128;
  localparam int ROWS    = 64;
  localparam int PAGES   = ROWS / 8;
  localparam int CELLS   = PAGES * COLUMNS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic [1:0] ACT_DOT   = 2'd0;
  localparam logic [1:0] ACT_BLIT  = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_TOGGLE = 2'd2;
  localparam logic [1:0] OP_KEEP   = 2'd3;

  localparam logic [2:0] MODE_CLEAR     = 3'd0;
  localparam logic [2:0] MODE_LAYER     = 3'd1;
  localparam logic [2:0] MODE_MULTIPLY  = 3'd2;
  localparam logic [2:0] MODE_CLEAR_POS = 3'd3;
  localparam logic [2:0] MODE_NEGATIVE  = 3'd4;
  localparam logic [2:0] MODE_INVERT    = 3'd5;

  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  // Result slots of one flush step, in emission order.
  localparam logic [2:0] SLOT_HOME_PAGE = 3'd0;
  localparam logic [2:0] SLOT_HOME_HI   = 3'd1;
  localparam logic [2:0] SLOT_HOME_LO   = 3'd2;
  localparam logic [2:0] SLOT_RUN_PAGE  = 3'd3;
  localparam logic [2:0] SLOT_RUN_HI    = 3'd4;
  localparam logic [2:0] SLOT_RUN_LO    = 3'd5;
  localparam logic [2:0] SLOT_DATA      = 3'd6;
  localparam logic [2:0] SLOT_NONE      = 3'd7;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] NIBBLE_MASK   = 8'h0f;
  localparam logic [7:0] TOP_PIXEL     = 8'h80;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [1:0] dot_op;
    logic       src_bit;
    logic [2:0] blit_mode;
  } pfd_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic       scan_done;
    logic       last;
  } pfd_out_t;

  // What one flush step has to send: enabled slots and the bytes behind them.
  typedef struct packed {
    logic [7:0] slot_en;
    logic [7:0] page_cmd;
    logic [7:0] col;
    logic [7:0] data;
    logic       done;
  } pfd_plan_t;

  function automatic logic [1:0] blit_op(input logic src, input logic [2:0] mode);
    logic [1:0] op;
    op = OP_KEEP;
    if (src) begin
      unique case (mode)
        MODE_CLEAR, MODE_CLEAR_POS, MODE_NEGATIVE: op = OP_CLEAR;
        MODE_LAYER, MODE_MULTIPLY:                 op = OP_SET;
        MODE_INVERT:                               op = OP_TOGGLE;
        default:                                   op = OP_KEEP;
      endcase
    end else begin
      unique case (mode)
        MODE_CLEAR, MODE_LAYER: op = OP_CLEAR;
        MODE_NEGATIVE:          op = OP_SET;
        default:                op = OP_KEEP;
      endcase
    end
    return op;
  endfunction

endpackage

>>> hw/rtl/page_framebuffer_dirty_flush.sv
// ----------------------------------------------------------------------------
// page_framebuffer_dirty_flush
// Page-organized monochrome frame store with a shadow-diff panel flush.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, in_data) takes one beat per item: a
// dot, a blit pixel or a flush step. Dots and blits produce no output beats.
// A flush step produces one to seven beats on the output channel (out_valid,
// out_ready, out_data), the final one flagged by last.
// Every item is read from the frame and shadow RAMs at acceptance, then
// modified and written back through the single write port of each RAM; no
// new item is taken before that write-back is done. A flush step then waits
// in a plan state until it hands its plan to the emitter, which sends one
// beat per cycle from an output register while the receiver is ready.
// Drawing items keep flowing while the emitter drains an earlier flush.
// After reset a clearing pass writes zero to every RAM entry, one entry per
// cycle, all COLUMNS*ROWS/8 of them (1024 at the default size); in_ready stays
// low during that pass. When the receiver stalls, the current beat holds in
// the output register and a following flush step waits in its plan stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_framebuffer_dirty_flush_macros.svh"

module page_framebuffer_dirty_flush import pfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pfd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pfd_out_t out_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_PLAN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [COL_W-1:0]  col_r;
  logic [PAGE_W-1:0] page_r;
  logic              run_r;

  // Item captured at acceptance, used in the write-back cycle.
  logic [1:0]        itm_act_r;
  logic [1:0]        itm_op_r;
  logic [7:0]        itm_mask_r;
  logic [ADDR_W-1:0] itm_addr_r;
  pfd_plan_t         plan_r;

  logic              accept;
  logic              x_ok, y_ok;
  logic [PAGE_W-1:0] pix_page;
  logic [ADDR_W-1:0] pix_addr, scan_addr, rd_addr;
  logic [1:0]        pix_op;

  logic [7:0]        frm_rd, shd_rd;
  logic              frm_we, shd_we;
  logic [ADDR_W-1:0] frm_wa, shd_wa;
  logic [7:0]        frm_wd, shd_wd, frm_mod;

  logic              col_zero, differs, scan_end;
  logic              plan_ready;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Pixel address: page row of bytes times column count, plus the column.
  assign x_ok      = ({1'b0, in_data.x_pos} < 9'(COLUMNS));
  assign y_ok      = (in_data.y_pos < 8'(ROWS));
  assign pix_page  = PAGE_W'(in_data.y_pos >> 3);
  assign pix_addr  = ADDR_W'(ADDR_W'(pix_page) * ADDR_W'(COLUMNS)) + ADDR_W'(in_data.x_pos);
  assign scan_addr = ADDR_W'(ADDR_W'(page_r) * ADDR_W'(COLUMNS)) + ADDR_W'(col_r);
  assign rd_addr   = (in_data.action == ACT_FLUSH) ? scan_addr : pix_addr;

  always_comb begin
    unique case (in_data.action)
      ACT_DOT:  pix_op = in_data.dot_op;
      ACT_BLIT: pix_op = blit_op(in_data.src_bit, in_data.blit_mode);
      default:  pix_op = OP_KEEP;
    endcase
    if (!(x_ok && y_ok)) begin
      pix_op = OP_KEEP;
    end
  end

  // Read-modify-write of the addressed frame byte.
  always_comb begin
    unique case (itm_op_r)
      OP_CLEAR:  frm_mod = frm_rd & ~itm_mask_r;
      OP_SET:    frm_mod = frm_rd | itm_mask_r;
      OP_TOGGLE: frm_mod = frm_rd ^ itm_mask_r;
      default:   frm_mod = frm_rd;
    endcase
  end

  assign col_zero = (col_r == '0);
  assign differs  = (frm_rd != shd_rd);
  assign scan_end = (col_r == COL_W'(COLUMNS - 1)) && (page_r == PAGE_W'(PAGES - 1));

  // Both RAMs are swept to zero during the clearing pass; after that the
  // frame takes pixel writes and the shadow takes copies of changed bytes.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      frm_we = 1'b1;  frm_wa = clr_addr_r;  frm_wd = 8'h00;
      shd_we = 1'b1;  shd_wa = clr_addr_r;  shd_wd = 8'h00;
    end else begin
      frm_we = (state_r == ST_READ) && (itm_act_r != ACT_FLUSH) && (itm_op_r != OP_KEEP);
      frm_wa = itm_addr_r;
      frm_wd = frm_mod;
      shd_we = (state_r == ST_READ) && (itm_act_r == ACT_FLUSH) && differs;
      shd_wa = itm_addr_r;
      shd_wd = frm_rd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = (itm_act_r == ACT_FLUSH) ? ST_PLAN : ST_IDLE;
      end
      default: begin
        if (plan_ready) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      col_r      <= '0;
      page_r     <= '0;
      run_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (accept) begin
        itm_act_r  <= in_data.action;
        itm_op_r   <= pix_op;
        itm_mask_r <= TOP_PIXEL >> in_data.y_pos[2:0];
        itm_addr_r <= rd_addr;
      end
      if ((state_r == ST_READ) && (itm_act_r == ACT_FLUSH)) begin
        // A home address at column zero, a run address when a run of changed
        // bytes starts, the data byte when it changed, else a filler beat.
        plan_r.slot_en  <= {~(col_zero | differs), differs,
                            {3{differs & ~run_r}}, {3{col_zero}}};
        plan_r.page_cmd <= CMD_PAGE_BASE + 8'(PAGES - 1) - 8'(page_r);
        plan_r.col      <= 8'(col_r);
        plan_r.data     <= frm_rd;
        plan_r.done     <= scan_end;
        if (scan_end) begin
          col_r  <= '0;
          page_r <= '0;
          run_r  <= 1'b0;
        end else begin
          run_r <= differs;
          if (col_r == COL_W'(COLUMNS - 1)) begin
            col_r  <= '0;
            page_r <= page_r + PAGE_W'(1);
          end else begin
            col_r <= col_r + COL_W'(1);
          end
        end
      end
    end
  end

  pfd_ram #(.WIDTH(8), .DEPTH(CELLS)) u_frame_ram (
    .clk     (clk),
    .wr_en   (frm_we),
    .wr_addr (frm_wa),
    .wr_data (frm_wd),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (frm_rd)
  );

  pfd_ram #(.WIDTH(8), .DEPTH(CELLS)) u_shadow_ram (
    .clk     (clk),
    .wr_en   (shd_we),
    .wr_addr (shd_wa),
    .wr_data (shd_wd),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (shd_rd)
  );

  pfd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan_valid (state_r == ST_PLAN),
    .plan_ready (plan_ready),
    .plan       (plan_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // A handed-over plan shows up as an output beat in the next cycle.
  `PFD_ASSERT_NEXT(a_plan_to_beat, clk, rst_n, (state_r == ST_PLAN) && plan_ready, out_valid)
  // Every accepted item goes to the write-back cycle next.
  `PFD_ASSERT_NEXT(a_accept_read, clk, rst_n, accept, state_r == ST_READ)
  // The frame RAM is never written by a flush step after the clearing pass.
  `PFD_ASSERT_SAME(a_flush_no_frame_wr, clk, rst_n, (state_r != ST_CLEAR) && frm_we, itm_act_r != ACT_FLUSH)
  // Frame and shadow writes never coincide outside the clearing pass.
  `PFD_ASSERT_SAME(a_one_writer, clk, rst_n, (state_r != ST_CLEAR) && frm_we, !shd_we)

endmodule

>>> hw/rtl/pfd_ram.sv
// ----------------------------------------------------------------------------
// pfd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/pfd_emit.sv
// ----------------------------------------------------------------------------
// pfd_emit
// Turns a flush plan into its beats, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfd_emit import pfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      plan_valid,
  output logic      plan_ready,
  input  pfd_plan_t plan,
  output logic      out_valid,
  input  logic      out_ready,
  output pfd_out_t  out_data
);

  logic      out_valid_r;
  pfd_out_t  out_r;
  logic      active_r;
  pfd_plan_t plan_r;
  logic [2:0] slot_r;

  logic       load_first;
  logic       load_next;
  logic [2:0] first_slot;
  logic [2:0] next_slot;
  pfd_out_t   first_beat;
  pfd_out_t   next_beat;

  // Lowest enabled slot at or above the start index.
  function automatic logic [2:0] find_slot(input logic [7:0] en, input logic [3:0] from);
    logic [2:0] sel;
    sel = SLOT_NONE;
    for (int i = 7; i >= 0; i--) begin
      if (en[i] && (4'(i) >= from)) begin
        sel = 3'(i);
      end
    end
    return sel;
  endfunction

  function automatic pfd_out_t build(input pfd_plan_t p, input logic [2:0] slot);
    pfd_out_t o;
    o.scan_done = p.done;
    o.last      = (((p.slot_en >> slot) >> 1) == 8'h00);
    unique case (slot)
      SLOT_HOME_PAGE, SLOT_RUN_PAGE: begin
        o.kind = KIND_CMD;  o.byte_value = p.page_cmd;
      end
      SLOT_HOME_HI: begin
        o.kind = KIND_CMD;  o.byte_value = CMD_COL_HI;
      end
      SLOT_HOME_LO: begin
        o.kind = KIND_CMD;  o.byte_value = 8'h00;
      end
      SLOT_RUN_HI: begin
        o.kind = KIND_CMD;  o.byte_value = CMD_COL_HI | (p.col >> 4);
      end
      SLOT_RUN_LO: begin
        o.kind = KIND_CMD;  o.byte_value = p.col & NIBBLE_MASK;
      end
      SLOT_DATA: begin
        o.kind = KIND_DATA; o.byte_value = p.data;
      end
      default: begin
        o.kind = KIND_NONE; o.byte_value = 8'h00;
      end
    endcase
    return o;
  endfunction

  assign plan_ready = !active_r && (!out_valid_r || out_ready);
  assign load_first = plan_valid && plan_ready;
  assign load_next  = active_r && out_ready;
  assign first_slot = find_slot(plan.slot_en, 4'd0);
  assign next_slot  = find_slot(plan_r.slot_en, {1'b0, slot_r} + 4'd1);
  assign first_beat = build(plan, first_slot);
  assign next_beat  = build(plan_r, next_slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
    end else if (load_first) begin
      out_valid_r <= 1'b1;
      plan_r      <= plan;
      slot_r      <= first_slot;
      out_r       <= first_beat;
      active_r    <= !first_beat.last;
    end else if (load_next) begin
      out_valid_r <= 1'b1;
      slot_r      <= next_slot;
      out_r       <= next_beat;
      active_r    <= !next_beat.last;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> sim/pfd_flush_checker.sv
// ----------------------------------------------------------------------------
// pfd_flush_checker
// Watches both channels of the frame buffer flush, keeps its own copy of the
// frame and shadow stores, predicts the panel bytes and compares each beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfd_flush_checker import pfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  pfd_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  pfd_out_t out_data,
  output int       mismatches,
  output int       beats_pending,
  output int       beats_checked,
  output int       scans_finished
);

  logic [7:0] frame_copy [CELLS];
  logic [7:0] shadow_copy [CELLS];
  int         scan_idx = 0;
  logic       run_open = 1'b0;
  pfd_out_t   panel_bytes_due [$];
  pfd_out_t   step_beats [$];
  int         error_total = 0;
  int         beat_total = 0;
  int         wrap_total = 0;

  task automatic note_error(input string msg);
    error_total++;
    $display("[%0t] flush check: %s", $time, msg);
  endtask

  task automatic compare_field(input string field, input int got, input int want,
                               input int beat_no);
    if (got != want) begin
      note_error($sformatf("beat %0d: %s is %0h, expected %0h", beat_no, field, got, want));
    end
  endtask

  function automatic logic [1:0] blend_to_op(input logic src, input logic [2:0] mode);
    case (mode)
      MODE_CLEAR:     return OP_CLEAR;
      MODE_LAYER:     return src ? OP_SET : OP_CLEAR;
      MODE_MULTIPLY:  return src ? OP_SET : OP_KEEP;
      MODE_CLEAR_POS: return src ? OP_CLEAR : OP_KEEP;
      MODE_NEGATIVE:  return src ? OP_CLEAR : OP_SET;
      MODE_INVERT:    return src ? OP_TOGGLE : OP_KEEP;
      default:        return OP_KEEP;
    endcase
  endfunction

  task automatic paint_pixel(input logic [7:0] x, input logic [7:0] y, input logic [1:0] op);
    int         idx;
    logic [7:0] bit_mask;
    if (x < COLUMNS && y < ROWS) begin
      idx      = int'(y >> 3) * COLUMNS + int'(x);
      bit_mask = TOP_PIXEL >> y[2:0];
      case (op)
        OP_CLEAR:  frame_copy[idx] = frame_copy[idx] & ~bit_mask;
        OP_SET:    frame_copy[idx] = frame_copy[idx] | bit_mask;
        OP_TOGGLE: frame_copy[idx] = frame_copy[idx] ^ bit_mask;
        default:   ;
      endcase
    end
  endtask

  task automatic add_beat(input logic [1:0] kind, input logic [7:0] value);
    pfd_out_t b;
    b            = '0;
    b.kind       = kind;
    b.byte_value = value;
    step_beats.push_back(b);
  endtask

  // Page command first (pages are numbered from the bottom), then the column
  // split into its high and low nibbles.
  task automatic add_address(input int col, input int page);
    logic [7:0] c;
    c = col[7:0];
    add_beat(KIND_CMD, CMD_PAGE_BASE + 8'(PAGES - 1 - page));
    add_beat(KIND_CMD, CMD_COL_HI | {4'h0, c[7:4]});
    add_beat(KIND_CMD, c & NIBBLE_MASK);
  endtask

  task automatic predict_flush_step();
    int       col;
    int       page;
    logic     at_end;
    pfd_out_t b;
    col    = scan_idx % COLUMNS;
    page   = scan_idx / COLUMNS;
    at_end = (scan_idx == CELLS - 1);
    step_beats.delete();
    if (col == 0) begin
      add_address(0, page);
    end
    if (frame_copy[scan_idx] != shadow_copy[scan_idx]) begin
      if (!run_open) begin
        run_open = 1'b1;
        add_address(col, page);
      end
      add_beat(KIND_DATA, frame_copy[scan_idx]);
      shadow_copy[scan_idx] = frame_copy[scan_idx];
    end else begin
      run_open = 1'b0;
    end
    if (step_beats.size() == 0) begin
      add_beat(KIND_NONE, 8'h00);
    end
    if (at_end) begin
      scan_idx = 0;
      run_open = 1'b0;
      wrap_total++;
    end else begin
      scan_idx++;
    end
    foreach (step_beats[i]) begin
      b           = step_beats[i];
      b.scan_done = at_end;
      b.last      = (i == step_beats.size() - 1);
      panel_bytes_due.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    pfd_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        frame_copy[i]  = '0;
        shadow_copy[i] = '0;
      end
      scan_idx = 0;
      run_open = 1'b0;
      panel_bytes_due.delete();
    end else begin
      // An output beat can never stem from an item taken at the same edge.
      if (out_valid && out_ready) begin
        beat_total++;
        if (panel_bytes_due.size() == 0) begin
          note_error($sformatf("beat %0d arrived with nothing due: kind %0h byte %02h",
                               beat_total, out_data.kind, out_data.byte_value));
        end else begin
          want = panel_bytes_due.pop_front();
          compare_field("kind", int'(out_data.kind), int'(want.kind), beat_total);
          compare_field("byte_value", int'(out_data.byte_value), int'(want.byte_value),
                        beat_total);
          compare_field("scan_done", int'(out_data.scan_done), int'(want.scan_done),
                        beat_total);
          compare_field("last", int'(out_data.last), int'(want.last), beat_total);
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.action)
          ACT_DOT:   paint_pixel(in_data.x_pos, in_data.y_pos, in_data.dot_op);
          ACT_BLIT:  paint_pixel(in_data.x_pos, in_data.y_pos,
                                 blend_to_op(in_data.src_bit, in_data.blit_mode));
          ACT_FLUSH: predict_flush_step();
          default:   ;
        endcase
      end
    end
    mismatches     <= error_total;
    beats_pending  <= panel_bytes_due.size();
    beats_checked  <= beat_total;
    scans_finished <= wrap_total;
  end

endmodule

>>> sim/page_framebuffer_dirty_flush_tb.sv
// ----------------------------------------------------------------------------
// page_framebuffer_dirty_flush_tb
// Drives dots, blit pixels and flush steps into the frame buffer flush block,
// stalls both channels at random and lets the checker judge every panel beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_framebuffer_dirty_flush_tb;
  import pfd_pkg::*;

  // Codes the package leaves unnamed because the block ignores them.
  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int RANDOM_PER_PHASE = 48;
  // The limit is five times a generous guess at a slow correct run: some 170
  // items, each with sender gaps, its time in the block and up to seven
  // stalled beats, plus the clearing pass after reset.
  localparam int CYCLE_LIMIT      = 40000;
  localparam int TAIL_CYCLES      = 24;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  pfd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pfd_out_t out_data;

  // Idle rates of the two sides, in percent of cycles.
  int send_gap_pct   = 33;
  int recv_stall_pct = 50;

  // The byte position the block's scan will visit next; the stimulus aims
  // its drawing just ahead of it so that flushes find dirty bytes and runs.
  int scan_cursor  = 0;
  int cycle_count  = 0;
  int dots_sent    = 0;
  int blits_sent   = 0;
  int flushes_sent = 0;
  int unused_sent  = 0;

  int mismatches;
  int beats_pending;
  int beats_checked;
  int scans_finished;

  always #1 clk = ~clk;

  page_framebuffer_dirty_flush DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pfd_flush_checker flush_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatches     (mismatches),
    .beats_pending  (beats_pending),
    .beats_checked  (beats_checked),
    .scans_finished (scans_finished)
  );

  // The receiver decides afresh every cycle whether it takes a beat. With a
  // stall rate of zero it is always ready.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake or a beat that never comes ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count, beats_pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Fields an item does not use still get random values, so every bit of
  // every field sees both levels over the run.
  function automatic pfd_in_t random_fields();
    pfd_in_t b;
    b.action    = 2'($urandom_range(3));
    b.x_pos     = 8'($urandom_range(255));
    b.y_pos     = 8'($urandom_range(255));
    b.dot_op    = 2'($urandom_range(3));
    b.src_bit   = 1'($urandom_range(1));
    b.blit_mode = 3'($urandom_range(7));
    return b;
  endfunction

  // Offers one beat on the input channel and returns at the edge that takes
  // it. Idle cycles go in front of the beat; once valid is up it stays up
  // with the same payload until the block is ready.
  task automatic push_beat(input pfd_in_t beat);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    case (beat.action)
      ACT_DOT:  dots_sent++;
      ACT_BLIT: blits_sent++;
      ACT_FLUSH: begin
        flushes_sent++;
        scan_cursor = (scan_cursor + 1) % CELLS;
      end
      default:  unused_sent++;
    endcase
  endtask

  task automatic dot(input int x, input int y, input logic [1:0] op);
    pfd_in_t b;
    b        = random_fields();
    b.action = ACT_DOT;
    b.x_pos  = 8'(x);
    b.y_pos  = 8'(y);
    b.dot_op = op;
    push_beat(b);
  endtask

  task automatic blit(input int x, input int y, input logic src, input logic [2:0] mode);
    pfd_in_t b;
    b           = random_fields();
    b.action    = ACT_BLIT;
    b.x_pos     = 8'(x);
    b.y_pos     = 8'(y);
    b.src_bit   = src;
    b.blit_mode = mode;
    push_beat(b);
  endtask

  task automatic flush_step();
    pfd_in_t b;
    b        = random_fields();
    b.action = ACT_FLUSH;
    push_beat(b);
  endtask

  // Picks the pixel of a drawing item. Most land a few bytes ahead of the
  // scan, some anywhere on the panel, and the rest off the panel, where
  // the block must ignore them.
  task automatic aim_pixel(inout pfd_in_t b);
    int where;
    int pos;
    where = $urandom_range(99);
    if (where < 75) begin
      pos     = (scan_cursor + $urandom_range(12)) % CELLS;
      b.x_pos = 8'(pos % COLUMNS);
      b.y_pos = 8'((pos / COLUMNS) * 8 + $urandom_range(7));
    end else if (where < 90) begin
      b.x_pos = 8'($urandom_range(COLUMNS - 1));
      b.y_pos = 8'($urandom_range(ROWS - 1));
    end else if (b.x_pos < COLUMNS && b.y_pos < ROWS) begin
      b.y_pos = b.y_pos | 8'hc0;
    end
  endtask

  // One random item: mostly drawing and flushing, with a few unused actions.
  task automatic random_item();
    pfd_in_t b;
    int      pick;
    b    = random_fields();
    pick = $urandom_range(99);
    if (pick < 40) begin
      b.action = ACT_DOT;
    end else if (pick < 60) begin
      b.action = ACT_BLIT;
    end else if (pick < 95) begin
      b.action = ACT_FLUSH;
    end else begin
      b.action = ACT_UNUSED;
    end
    if (b.action == ACT_DOT || b.action == ACT_BLIT) begin
      aim_pixel(b);
    end
    push_beat(b);
  endtask

  initial begin
    pfd_in_t b;

    // Reset is held low at the start; the block then clears its stores with
    // in_ready low, and the first beat simply waits that out.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Paint the first bytes of page 0: the top pixel of
    // column 0, the bottom pixel of column 1, and a toggle, clear and keep
    // on column 3. Two off-panel dots must leave the frame alone.
    dot(0, 0, OP_SET);
    dot(1, 7, OP_SET);
    dot(3, 3, OP_TOGGLE);
    dot(3, 2, OP_TOGGLE);
    dot(3, 2, OP_CLEAR);
    dot(3, 6, OP_KEEP);
    dot(COLUMNS, 0, OP_SET);
    dot(0, ROWS, OP_SET);

    // Column 0 sends the home address, then a fresh run address and the
    // data byte: the longest step there is. Column 1 continues the run with
    // data only, column 2 is clean and ends the run with a filler beat, and
    // column 3 opens a new run.
    repeat (4) flush_step();

    // Every blend mode with a set source bit, one row each on column 5 (modes
    // 6 and 7 unused), then clear, layer, negative and invert on a clear one.
    for (int m = int'(MODE_CLEAR); m <= int'(MODE_SPARE_HI); m++) begin
      blit(5, m, 1'b1, 3'(m));
    end
    blit(5, int'(MODE_CLEAR), 1'b0, MODE_CLEAR);
    blit(5, int'(MODE_LAYER), 1'b0, MODE_LAYER);
    blit(5, int'(MODE_NEGATIVE), 1'b0, MODE_NEGATIVE);
    blit(5, int'(MODE_INVERT), 1'b0, MODE_INVERT);

    // The unused action changes nothing; column 4 is clean, column 5 is not.
    b        = random_fields();
    b.action = ACT_UNUSED;
    push_beat(b);
    flush_step();
    flush_step();

    // First random phase: sender idles a third of the time, receiver half.
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      random_item();
    end

    // Second phase swaps the idle rates, the third runs at full speed.
    send_gap_pct   = 50;
    recv_stall_pct = 33;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      random_item();
    end
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      random_item();
    end
    in_valid <= 1'b0;

    // Let the checker see the last item, drain every expected beat, then
    // give the block a few more cycles to show any beat it should not send.
    @(posedge clk);
    while (beats_pending != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d dots, %0d blit pixels, %0d flush steps and %0d unused actions",
             dots_sent, blits_sent, flushes_sent, unused_sent);
    $display("checked %0d panel beats over %0d full frame scans, %0d mismatches",
             beats_checked, scans_finished, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> page_framebuffer_dirty_flush.f
+incdir+hw/rtl
hw/rtl/pfd_pkg.sv
hw/rtl/pfd_ram.sv
hw/rtl/pfd_emit.sv
hw/rtl/page_framebuffer_dirty_flush.sv
sim/pfd_flush_checker.sv
sim/page_framebuffer_dirty_flush_tb.sv
